// File: rtl/core/csw_pkg.sv
// Shared types, widths and codes for the cutoff switching weight core.
package csw_pkg;

   localparam int R_W      = 16;          // Q4.12 distance
   localparam int SQ_W     = 2 * R_W;     // Q8.24 square
   localparam int B_W      = SQ_W + 2;    // roff2 + 2r2 - 3ron2
   localparam int PROD_W   = 2 * SQ_W;    // square of a square
   localparam int PP_W     = SQ_W + B_W;  // one partial product
   localparam int FRAC_W   = 16;          // Q1.16 weight fraction
   localparam int Q_W      = FRAC_W + 1;  // quotient bits
   localparam int NUM_W    = PROD_W + B_W;        // a^2 * b
   localparam int DEN_W    = PROD_W + SQ_W;       // d^3
   localparam int REM_W    = NUM_W + FRAC_W;      // scaled numerator
   localparam int DIV_W    = DEN_W + FRAC_W;      // d^3 aligned to the top quotient bit
   localparam int CELLS    = Q_W;                 // one division cell per quotient bit
   localparam int WEIGHT_W = Q_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1 << FRAC_W);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;

   // configuration register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = R_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_ON_RADIUS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_OFF_RADIUS = 2'd2;

   localparam logic [R_W-1:0] ON_RADIUS_RESET  = 16'd4096;
   localparam logic [R_W-1:0] OFF_RADIUS_RESET = 16'd4915;

   // which branch of the weight an item takes
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FULL = 2'd0;
   localparam kind_type KIND_ZERO = 2'd1;
   localparam kind_type KIND_BAND = 2'd2;

   typedef struct packed {
      logic           enable;
      logic [R_W-1:0] on_radius;
      logic [R_W-1:0] off_radius;
   } cfg_type;

   // payload handed from cell to cell
   typedef struct packed {
      kind_type         kind;
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] dsh;
      logic [Q_W-1:0]   quo;
   } div_data_type;

endpackage

// File: rtl/core/csw_front.sv
// Front pipeline: squares, band decision, numerator and denominator products.
module csw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  csw_pkg::cfg_type     cfg,
   input  logic                 up_valid,
   input  logic [csw_pkg::R_W-1:0] up_distance,
   output logic                 up_ready,
   output logic                 dn_valid,
   output csw_pkg::div_data_type dn_data,
   input  logic                 dn_ready
);

   logic [5:0] valid_ff;
   logic [5:0] rdy;

   // stage 0: captured distance
   logic [csw_pkg::R_W-1:0]  r0_ff;
   // stage 1: squares and branch
   logic [csw_pkg::SQ_W-1:0] r2_ff, ron2_ff, roff2_ff;
   csw_pkg::kind_type        kind1_ff, kind1_in;
   // stage 2: differences
   logic [csw_pkg::SQ_W-1:0] a_ff, d2s_ff;
   logic [csw_pkg::B_W-1:0]  b2_ff;
   csw_pkg::kind_type        kind2_ff;
   logic [csw_pkg::B_W:0]    b_wide;
   // stage 3: squares of differences
   logic [csw_pkg::PROD_W-1:0] asq_ff, dsq_ff;
   logic [csw_pkg::SQ_W-1:0]   d3_ff;
   logic [csw_pkg::B_W-1:0]    b3_ff;
   csw_pkg::kind_type          kind3_ff;
   // stage 4: partial products
   logic [csw_pkg::PP_W-1:0]   pa_lo_ff, pa_hi_ff;
   logic [csw_pkg::PROD_W-1:0] pd_lo_ff, pd_hi_ff;
   csw_pkg::kind_type          kind4_ff;
   // stage 5: assembled dividend and divisor
   csw_pkg::div_data_type      out_ff, out_in;
   logic [csw_pkg::NUM_W-1:0]  num_sum;
   logic [csw_pkg::DEN_W-1:0]  den_sum;

   // a stage takes new data when it is empty or its successor takes
   assign rdy[5] = !valid_ff[5] || dn_ready;
   assign rdy[4] = !valid_ff[4] || rdy[5];
   assign rdy[3] = !valid_ff[3] || rdy[4];
   assign rdy[2] = !valid_ff[2] || rdy[3];
   assign rdy[1] = !valid_ff[1] || rdy[2];
   assign rdy[0] = !valid_ff[0] || rdy[1];
   assign up_ready = rdy[0];

   always_comb begin
      priority if (!cfg.enable || r0_ff <= cfg.on_radius) begin
         kind1_in = csw_pkg::KIND_FULL;
      end else if (r0_ff >= cfg.off_radius) begin
         kind1_in = csw_pkg::KIND_ZERO;
      end else begin
         kind1_in = csw_pkg::KIND_BAND;
      end
   end

   // only meaningful inside the band, where it is positive
   assign b_wide = (csw_pkg::B_W+1)'(roff2_ff) + {2'b0, r2_ff, 1'b0}
                 - ({2'b0, ron2_ff, 1'b0} + (csw_pkg::B_W+1)'(ron2_ff));

   assign num_sum = {pa_hi_ff, {csw_pkg::SQ_W{1'b0}}}
                  + csw_pkg::NUM_W'(pa_lo_ff);
   assign den_sum = {pd_hi_ff, {csw_pkg::SQ_W{1'b0}}}
                  + csw_pkg::DEN_W'(pd_lo_ff);

   always_comb begin
      out_in.kind = kind4_ff;
      out_in.rem  = {num_sum, {csw_pkg::FRAC_W{1'b0}}};
      out_in.dsh  = {den_sum, {csw_pkg::FRAC_W{1'b0}}};
      out_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= up_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
         if (rdy[3]) valid_ff[3] <= valid_ff[2];
         if (rdy[4]) valid_ff[4] <= valid_ff[3];
         if (rdy[5]) valid_ff[5] <= valid_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && up_valid) begin
         r0_ff <= up_distance;
      end
      if (rdy[1] && valid_ff[0]) begin
         r2_ff    <= csw_pkg::SQ_W'(r0_ff) * csw_pkg::SQ_W'(r0_ff);
         ron2_ff  <= csw_pkg::SQ_W'(cfg.on_radius) * csw_pkg::SQ_W'(cfg.on_radius);
         roff2_ff <= csw_pkg::SQ_W'(cfg.off_radius) * csw_pkg::SQ_W'(cfg.off_radius);
         kind1_ff <= kind1_in;
      end
      if (rdy[2] && valid_ff[1]) begin
         a_ff     <= roff2_ff - r2_ff;
         d2s_ff   <= roff2_ff - ron2_ff;
         b2_ff    <= b_wide[csw_pkg::B_W-1:0];
         kind2_ff <= kind1_ff;
      end
      if (rdy[3] && valid_ff[2]) begin
         asq_ff   <= csw_pkg::PROD_W'(a_ff) * csw_pkg::PROD_W'(a_ff);
         dsq_ff   <= csw_pkg::PROD_W'(d2s_ff) * csw_pkg::PROD_W'(d2s_ff);
         d3_ff    <= d2s_ff;
         b3_ff    <= b2_ff;
         kind3_ff <= kind2_ff;
      end
      if (rdy[4] && valid_ff[3]) begin
         pa_lo_ff <= csw_pkg::PP_W'(asq_ff[csw_pkg::SQ_W-1:0]) * csw_pkg::PP_W'(b3_ff);
         pa_hi_ff <= csw_pkg::PP_W'(asq_ff[csw_pkg::PROD_W-1:csw_pkg::SQ_W])
                   * csw_pkg::PP_W'(b3_ff);
         pd_lo_ff <= csw_pkg::PROD_W'(dsq_ff[csw_pkg::SQ_W-1:0]) * csw_pkg::PROD_W'(d3_ff);
         pd_hi_ff <= csw_pkg::PROD_W'(dsq_ff[csw_pkg::PROD_W-1:csw_pkg::SQ_W])
                   * csw_pkg::PROD_W'(d3_ff);
         kind4_ff <= kind3_ff;
      end
      if (rdy[5] && valid_ff[4]) begin
         out_ff <= out_in;
      end
   end

   assign dn_valid = valid_ff[5];
   assign dn_data  = out_ff;

endmodule

// File: rtl/core/csw_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the rest on.
module csw_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  csw_pkg::div_data_type up_data,
   output logic                  up_ready,
   output logic                  dn_valid,
   output csw_pkg::div_data_type dn_data,
   input  logic                  dn_ready
);

   logic                     valid_ff;
   csw_pkg::div_data_type    data_ff, data_in;
   logic [csw_pkg::REM_W:0]  diff;
   logic                     take;

   assign up_ready = !valid_ff || dn_ready;

   assign diff = {1'b0, up_data.rem} - (csw_pkg::REM_W+1)'(up_data.dsh);
   assign take = !diff[csw_pkg::REM_W];

   always_comb begin
      data_in.kind = up_data.kind;
      data_in.rem  = take ? diff[csw_pkg::REM_W-1:0] : up_data.rem;
      data_in.dsh  = up_data.dsh >> 1;
      data_in.quo  = {up_data.quo[csw_pkg::Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/core/cutoff_switching_weight_core.sv
// Top level of the cutoff switching weight core: registers, front pipeline, divider row, output.
//
//   port group   direction  handshake            payload
//   req_         in         req_valid/req_stall  req_pair_distance [15:0] Q4.12
//   rsp_         out        rsp_valid/rsp_stall  rsp_switch_weight [16:0] Q1.16
//   csr_         in         csr_valid/csr_ready  csr_index [1:0], csr_wdata [15:0]
//
// One distance enters per cycle while req_stall is low; its weight passes through
// 6 front stages, 17 division cells and 1 output register.
// Every stage is fully pipelined, so one transaction per cycle goes through while rsp_stall is low;
// each division cell settles one quotient bit.
// reset is synchronous: it empties the pipeline and loads the register defaults.
// rsp_stall freezes only stages that are full; bubbles keep closing up, and
// req_stall rises once every stage holds a transaction.
module cutoff_switching_weight_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [csw_pkg::R_W-1:0]           req_pair_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [csw_pkg::WEIGHT_W-1:0]      rsp_switch_weight,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   csw_pkg::cfg_type cfg_ff;

   logic [csw_pkg::CELLS:0]  cell_valid;
   logic [csw_pkg::CELLS:0]  cell_ready;
   csw_pkg::div_data_type    cell_data [0:csw_pkg::CELLS];

   logic                         rsp_valid_ff;
   logic [csw_pkg::WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic                         out_ready;
   logic                         front_ready;
   csw_pkg::div_data_type        last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b0;
         cfg_ff.on_radius  <= csw_pkg::ON_RADIUS_RESET;
         cfg_ff.off_radius <= csw_pkg::OFF_RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            csw_pkg::CSR_SWITCH_ENABLE:     cfg_ff.enable     <= csr_wdata[0];
            csw_pkg::CSR_SWITCH_ON_RADIUS:  cfg_ff.on_radius  <= csr_wdata;
            csw_pkg::CSR_SWITCH_OFF_RADIUS: cfg_ff.off_radius <= csr_wdata;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   csw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .up_valid    (req_valid),
      .up_distance (req_pair_distance),
      .up_ready    (front_ready),
      .dn_valid    (cell_valid[0]),
      .dn_data     (cell_data[0]),
      .dn_ready    (cell_ready[0])
   );

   assign req_stall = !front_ready;

   for (genvar k = 0; k < csw_pkg::CELLS; k++) begin : g_cell
      csw_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[k]),
         .up_data  (cell_data[k]),
         .up_ready (cell_ready[k]),
         .dn_valid (cell_valid[k+1]),
         .dn_data  (cell_data[k+1]),
         .dn_ready (cell_ready[k+1])
      );
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign cell_ready[csw_pkg::CELLS] = out_ready;
   assign last = cell_data[csw_pkg::CELLS];

   always_comb begin
      unique case (last.kind)
         csw_pkg::KIND_FULL: rsp_weight_in = csw_pkg::WEIGHT_ONE;
         csw_pkg::KIND_BAND: rsp_weight_in = (last.quo > csw_pkg::WEIGHT_ONE)
                                           ? csw_pkg::WEIGHT_ONE : last.quo;
         default:            rsp_weight_in = csw_pkg::WEIGHT_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cell_valid[csw_pkg::CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cell_valid[csw_pkg::CELLS]) begin
         rsp_weight_ff <= rsp_weight_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switch_weight = rsp_weight_ff;

   // the weight never exceeds 1.0
   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_switch_weight <= csw_pkg::WEIGHT_ONE)
      else $error("switch weight above 1.0");

   // input backpressure only appears behind a stalled, full output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

   // a transaction leaving the divider row lands in the output register
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[csw_pkg::CELLS] && out_ready) |=> rsp_valid)
      else $error("divider result lost at output");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the cutoff switching weight core with an exact weight predictor.
module testbench;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 520;
   localparam logic [csw_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [csw_pkg::R_W-1:0]      distance;
      logic [csw_pkg::WEIGHT_W-1:0] weight;
   } weight_due_type;

   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_stall;
   logic [csw_pkg::R_W-1:0]         req_pair_distance = '0;
   logic                            rsp_valid;
   logic                            rsp_stall         = 1'b0;
   logic [csw_pkg::WEIGHT_W-1:0]    rsp_switch_weight;
   logic                            csr_valid         = 1'b0;
   logic                            csr_ready;
   logic [csw_pkg::CSR_INDEX_W-1:0] csr_index         = csw_pkg::CSR_SWITCH_ENABLE;
   logic [csw_pkg::CSR_DATA_W-1:0]  csr_wdata         = '0;

   // shadow copy of the switching registers
   logic                    sw_enable;
   logic [csw_pkg::R_W-1:0] sw_on_radius;
   logic [csw_pkg::R_W-1:0] sw_off_radius;

   weight_due_type weights_due[$];
   weight_due_type head;
   int          failures      = 0;
   int          cycles        = 0;
   int          items_sent    = 0;
   int          settings_used = 0;
   int          full_count    = 0;
   int          zero_count    = 0;
   int          band_count    = 0;
   bit          steady        = 1'b0;
   int          stall_run     = 0;
   int unsigned stall_roll;

   cutoff_switching_weight_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pair_distance (req_pair_distance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_switch_weight (rsp_switch_weight),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles, %0d weights still due",
                  $time, cycles, weights_due.size());
         $display("FAIL cutoff_switching_weight_core");
         $finish;
      end
   end

   // receiver back-pressure: mostly short runs, now and then a long one
   always @(posedge clock) begin
      if (steady) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run = stall_run - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         rsp_stall <= (stall_roll < 35);
         stall_run = (stall_roll % 10 == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (weights_due.size() == 0) begin
            $display("%0t ns: weight %0d with none expected", $time, rsp_switch_weight);
            failures++;
         end else begin
            head = weights_due.pop_front();
            if (rsp_switch_weight !== head.weight) begin
               $display("%0t ns: distance %0d: expected weight %0d, actual %0d",
                        $time, head.distance, head.weight, rsp_switch_weight);
               failures++;
            end
         end
      end
   end

   // exact S(r) in Q1.16, quotient truncated
   function automatic logic [csw_pkg::WEIGHT_W-1:0] switching_weight(
         input logic [csw_pkg::R_W-1:0] r);
      logic [127:0] r2, on2, off2, a, b, d, num, den, quo;
      if (!sw_enable || r <= sw_on_radius) return csw_pkg::WEIGHT_ONE;
      if (r >= sw_off_radius) return csw_pkg::WEIGHT_ZERO;
      r2   = 128'(r) * 128'(r);
      on2  = 128'(sw_on_radius) * 128'(sw_on_radius);
      off2 = 128'(sw_off_radius) * 128'(sw_off_radius);
      a    = off2 - r2;
      b    = off2 + 2 * r2 - 3 * on2;
      d    = off2 - on2;
      num  = (a * a * b) << csw_pkg::FRAC_W;
      den  = d * d * d;
      quo  = num / den;
      if (quo > 128'(csw_pkg::WEIGHT_ONE)) return csw_pkg::WEIGHT_ONE;
      return quo[csw_pkg::WEIGHT_W-1:0];
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // lean on the switching band and its borders
   function automatic logic [csw_pkg::R_W-1:0] pick_distance();
      int unsigned roll;
      int          lo, hi;
      roll = $urandom_range(0, 99);
      if (sw_on_radius < sw_off_radius && roll < 70) begin
         lo = int'(sw_on_radius) - 2;
         hi = int'(sw_off_radius) + 2;
         if (lo < 0) lo = 0;
         if (hi > 65535) hi = 65535;
         return csw_pkg::R_W'($urandom_range(hi, lo));
      end
      if (roll < 85) begin
         case ($urandom_range(0, 3))
            0:       return sw_on_radius;
            1:       return sw_on_radius + 1'b1;
            2:       return sw_off_radius - 1'b1;
            default: return sw_off_radius;
         endcase
      end
      return csw_pkg::R_W'($urandom());
   endfunction

   task automatic send_distance(input logic [csw_pkg::R_W-1:0] distance);
      weight_due_type due;
      int             gap;
      req_valid         <= 1'b1;
      req_pair_distance <= distance;
      do @(posedge clock); while (req_stall);
      due.distance = distance;
      due.weight   = switching_weight(distance);
      weights_due  = {weights_due, due};
      items_sent++;
      if (due.weight == csw_pkg::WEIGHT_ONE) full_count++;
      else if (due.weight == csw_pkg::WEIGHT_ZERO) zero_count++;
      else band_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // keep csr_valid up across back-to-back writes; drop it after the last one
   task automatic write_csr(input logic [csw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [csw_pkg::CSR_DATA_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         csw_pkg::CSR_SWITCH_ENABLE:     sw_enable     = data[0];
         csw_pkg::CSR_SWITCH_ON_RADIUS:  sw_on_radius  = data;
         csw_pkg::CSR_SWITCH_OFF_RADIUS: sw_off_radius = data;
         default: ;
      endcase
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (weights_due.size() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [csw_pkg::CSR_DATA_W-1:0] enable_word,
                                 input logic [csw_pkg::R_W-1:0] on_r,
                                 input logic [csw_pkg::R_W-1:0] off_r,
                                 input bit poke_unmapped);
      wait_drained();
      if (poke_unmapped) write_csr(CSR_UNMAPPED, csw_pkg::CSR_DATA_W'($urandom()), 1'b0);
      write_csr(csw_pkg::CSR_SWITCH_ENABLE, enable_word, 1'b0);
      write_csr(csw_pkg::CSR_SWITCH_ON_RADIUS, on_r, 1'b0);
      write_csr(csw_pkg::CSR_SWITCH_OFF_RADIUS, off_r, 1'b1);
      settings_used++;
   endtask

   task automatic test_reset_defaults();
      send_distance(16'd0);
      send_distance(16'd4500);
      send_distance(16'hFFFF);
   endtask

   task automatic test_band_edges();
      apply_settings(16'h0001, csw_pkg::ON_RADIUS_RESET, csw_pkg::OFF_RADIUS_RESET, 1'b0);
      send_distance(csw_pkg::ON_RADIUS_RESET);
      send_distance(csw_pkg::ON_RADIUS_RESET + 1'b1);
      send_distance(16'd4500);
      send_distance(csw_pkg::OFF_RADIUS_RESET - 1'b1);
      send_distance(csw_pkg::OFF_RADIUS_RESET);
   endtask

   task automatic test_radius_extremes();
      apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
      send_distance(16'd0);
      send_distance(16'd1);
      send_distance(16'h8000);
      send_distance(16'hFFFE);
      send_distance(16'hFFFF);
      apply_settings(16'h8001, 16'hFFFD, 16'hFFFF, 1'b0);
      send_distance(16'hFFFD);
      send_distance(16'hFFFE);
      send_distance(16'hFFFF);
      apply_settings(16'h0001, 16'd0, 16'd0, 1'b0);
      send_distance(16'd0);
      send_distance(16'd1);
   endtask

   // inner radius at or above the outer one: only the compares decide
   task automatic test_crossed_radii();
      apply_settings(16'h0001, 16'd5000, 16'd3000, 1'b0);
      send_distance(16'd3000);
      send_distance(16'd4000);
      send_distance(16'd5001);
      apply_settings(16'h0001, 16'd2000, 16'd2000, 1'b0);
      send_distance(16'd2000);
      send_distance(16'd2001);
   endtask

   task automatic test_register_map();
      apply_settings(16'h0001, 16'd2000, 16'd2000, 1'b1);
      send_distance(16'd2001);
      // enable word with bit 0 clear and every upper bit set
      apply_settings(16'hFFFE, csw_pkg::ON_RADIUS_RESET, csw_pkg::OFF_RADIUS_RESET, 1'b0);
      send_distance(16'd4500);
   endtask

   task automatic test_random_sweep();
      int                             start, phase, length;
      int unsigned                    mode;
      logic [csw_pkg::CSR_DATA_W-1:0] enable_word;
      logic [csw_pkg::R_W-1:0]        on_r, off_r;
      start = items_sent;
      phase = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 7);
         enable_word    = csw_pkg::CSR_DATA_W'($urandom());
         enable_word[0] = ($urandom_range(0, 7) != 0);
         case (mode)
            0: begin
               on_r  = ($urandom_range(0, 1) != 0) ? 16'd0
                                                   : csw_pkg::R_W'($urandom_range(0, 50));
               off_r = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                   : csw_pkg::R_W'($urandom_range(65000, 65535));
            end
            1: begin
               on_r  = csw_pkg::R_W'($urandom_range(1000, 60000));
               off_r = on_r + csw_pkg::R_W'($urandom_range(1, 3));
            end
            2: begin
               off_r = csw_pkg::R_W'($urandom());
               on_r  = off_r + csw_pkg::R_W'($urandom_range(0, 300));
            end
            3: begin
               on_r  = csw_pkg::R_W'($urandom());
               off_r = csw_pkg::R_W'($urandom());
            end
            default: begin
               on_r  = csw_pkg::R_W'($urandom_range(0, 40000));
               off_r = on_r + csw_pkg::R_W'($urandom_range(64, 20000));
            end
         endcase
         apply_settings(enable_word, on_r, off_r, ($urandom_range(0, 3) == 0));
         steady = (phase == 2);
         length = steady ? 80 : $urandom_range(15, 60);
         repeat (length) begin
            send_distance(pick_distance());
            // hold the sender until the pipeline has emptied
            if ($urandom_range(0, 99) == 0) wait_drained();
         end
         steady = 1'b0;
         phase++;
      end
   endtask

   initial begin
      sw_enable     = 1'b0;
      sw_on_radius  = csw_pkg::ON_RADIUS_RESET;
      sw_off_radius = csw_pkg::OFF_RADIUS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_band_edges();
      test_radius_extremes();
      test_crossed_radii();
      test_register_map();
      test_random_sweep();
      wait_drained();
      repeat (40) @(posedge clock);
      $display("covered %0d distances under %0d register settings", items_sent, settings_used);
      $display("weights: %0d full, %0d zero, %0d inside the band; %0d mismatches",
               full_count, zero_count, band_count, failures);
      if (failures == 0) begin
         $display("PASS cutoff_switching_weight_core");
      end else begin
         $display("FAIL cutoff_switching_weight_core");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/csw_pkg.sv
rtl/core/csw_front.sv
rtl/core/csw_div_cell.sv
rtl/core/cutoff_switching_weight_core.sv
bench/testbench.sv
